@@ hw/rtl/c3e_pkg.sv @@
`timescale 1ns / 1ps

package c3e_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int SUM_W      = 12;

    localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // one window column, top row first
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // one line buffer entry: the two stored rows at one column
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } lb_t;

    function automatic logic [DIM_W-1:0] sat_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] hi
    );
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) r = DIM_MIN;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

    // emboss kernel {-2,-1,0; -1,1,1; 0,1,2}, clamped to 0..255
    function automatic pix_t emboss(
        input col_t c2,
        input col_t c1,
        input pix_t mid,
        input pix_t pix
    );
        logic signed [SUM_W-1:0] s;
        pix_t r;
        s = -(SUM_W'(c2.top) <<< 1) - SUM_W'(c1.top) - SUM_W'(c2.mid)
            + SUM_W'(c1.mid) + SUM_W'(mid) + SUM_W'(c1.bot) + (SUM_W'(pix) <<< 1);
        if (s < 0) r = '0;
        else if (s > SUM_W'(255)) r = 8'd255;
        else r = s[PIX_W-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/conv3x3_emboss_clamp.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata: pixel_value; tuser: frame_start
// m_       out  m_tvalid/m_tready   tdata: filtered_value, centre_column, centre_row;
//                                   tlast: frame_last
// cfg_     in   cfg_we              cfg_index, cfg_data
//
// one pixel per clock sustained while s_tready stays high; a result passes through
// the line buffer read register and pixel register, then the window cells and output register.
// reset clears counters, window cells and valid flags; line buffer is not cleared.
// s_tready drops only while an interior result sits in the pipeline and the
// output register is full and stalled.

module conv3x3_emboss_clamp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] pixel_value
    input  logic                      s_tuser,   // [0] frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [7:0] filtered_value, [17:8] centre_column,
                                                 // [27:18] centre_row, [31:28] zero
    output logic                      m_tlast,   // frame_last
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [c3e_pkg::DIM_W-1:0] cfg_data
);
    import c3e_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    logic             m_valid_reg;
    pix_t             m_value_reg;
    logic [COL_W-1:0] m_col_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic             m_last_reg;

    logic             accept;
    logic             move;
    logic             s1_fire;
    logic             out_free;

    lb_t              lb_rd;
    lb_t              lb_wr;
    col_t             col_new;
    col_t             col_c1;
    col_t             col_c2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = sat_dim(width_reg, WIDTH_MAX);
    assign h_eff = sat_dim(height_reg, HEIGHT_MAX);

    assign out_free = !m_valid_reg || m_tready;
    assign move     = !s1_valid_reg || !s1_emit_reg || out_free;
    assign s_tready = move;
    assign accept   = s_tvalid && move;
    assign s1_fire  = s1_valid_reg && move;

    // position of the arriving pixel and the next one
    always_comb begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;
        col_inc = {1'b0, col_cur} + DIM_W'(1);
        row_inc = {1'b0, row_cur} + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_comb begin
        s1_valid_next = move ? s_tvalid : s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_tdata;
            s1_col_reg  <= col_cur;
            s1_row_reg  <= row_cur;
            s1_emit_reg <= (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
            s1_last_reg <= ({1'b0, col_cur} == w_eff - DIM_W'(1))
                        && ({1'b0, row_cur} == h_eff - DIM_W'(1));
        end
    end

    assign lb_wr.upper  = lb_rd.middle;
    assign lb_wr.middle = s1_pix_reg;

    c3e_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    assign col_new.top = lb_rd.upper;
    assign col_new.mid = lb_rd.middle;
    assign col_new.bot = s1_pix_reg;

    // window cells: column c-1, then column c-2
    c3e_cell u_cell_c1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_fire),
        .col_in   (col_new),
        .col_out  (col_c1)
    );

    c3e_cell u_cell_c2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s1_fire),
        .col_in   (col_c1),
        .col_out  (col_c2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_emit_reg) begin
            m_value_reg <= emboss(col_c2, col_c1, lb_rd.middle, s1_pix_reg);
            m_col_reg   <= s1_col_reg - COL_W'(1);
            m_row_reg   <= s1_row_reg - ROW_W'(1);
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_row_reg, m_col_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    a_emit_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && s1_emit_reg |=> m_valid_reg)
        else $error("interior result did not reach the output register");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s1_emit_reg && m_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_emit_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_emit_reg |-> s1_col_reg >= COL_W'(2) && s1_row_reg >= ROW_W'(2))
        else $error("result flagged for a border pixel");

    a_out_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_col_reg != '0 && m_row_reg != '0)
        else $error("output centre lies on the border");

endmodule

@@ hw/rtl/c3e_cell.sv @@
`timescale 1ns / 1ps

module c3e_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  c3e_pkg::col_t col_in,
    output c3e_pkg::col_t col_out
);
    import c3e_pkg::*;

    col_t col_reg;
    col_t col_next;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

@@ hw/rtl/c3e_line_buf.sv @@
`timescale 1ns / 1ps

module c3e_line_buf (
    input  logic                    aclk,
    input  logic                    rd_en,
    input  logic [c3e_pkg::COL_W-1:0] rd_addr,
    input  logic                    wr_en,
    input  logic [c3e_pkg::COL_W-1:0] wr_addr,
    input  c3e_pkg::lb_t            wr_data,
    output c3e_pkg::lb_t            rd_data
);
    import c3e_pkg::*;

    lb_t lb_mem [MAX_WIDTH];
    lb_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lb_mem[wr_addr] <= wr_data;
        end
    end

    // same-address write in this cycle forwards its data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_reg <= wr_data;
            end else begin
                rd_reg <= lb_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import c3e_pkg::*;

    localparam int TAIL_CYCLES  = 8;
    localparam int QUIET_GUARD  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 1000000;

    typedef struct packed {
        logic [7:0] pix;
        logic       fs;
    } pixel_item_t;

    // same bit order as {m_tlast, m_tdata}
    typedef struct packed {
        logic       flast;
        logic [3:0] pad;
        logic [9:0] crow;
        logic [9:0] ccol;
        logic [7:0] fval;
    } emboss_res_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [DIM_W-1:0] cfg_data  = '0;

    conv3x3_emboss_clamp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending pixels and the filtered results they must produce
    pixel_item_t pixel_q[$];
    emboss_res_t embossed_q[$];

    // shadow of the filter state
    lb_t              line_mem[MAX_WIDTH];
    col_t             win_old;
    col_t             win_new;
    int               col_cnt;
    int               row_cnt;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    int   s_idle_pct  = 0;
    int   m_stall_pct = 0;
    bit   long_hold_go = 1'b0;
    bit   hold_used    = 1'b0;
    int   hold_left    = 0;
    logic s_took       = 1'b0;
    bit   quiet        = 1'b0;

    int errors       = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int n_configs    = 0;
    int cur_w        = 640;
    int cur_h        = 480;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

    function automatic int used_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v < 3) return 3;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic pix_t pick_pixel();
        int k;
        k = $urandom_range(7);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hFF;
        return pix_t'($urandom);
    endfunction

    task automatic predict_emboss(input pix_t pix, input logic fs);
        int          w, h, c, r, acc;
        pix_t        top, mid;
        emboss_res_t res;
        w = used_dim(width_reg, MAX_WIDTH);
        h = used_dim(height_reg, MAX_HEIGHT);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c   = col_cnt;
        r   = row_cnt;
        top = line_mem[c].upper;
        mid = line_mem[c].middle;
        if (c >= 2 && r >= 2) begin
            acc = -2 * int'(win_old.top) - int'(win_new.top) - int'(win_old.mid)
                  + int'(win_new.mid) + int'(mid) + int'(win_new.bot) + 2 * int'(pix);
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            res.fval  = 8'(acc);
            res.ccol  = 10'(c - 1);
            res.crow  = 10'(r - 1);
            res.pad   = '0;
            res.flast = (c == w - 1) && (r == h - 1);
            embossed_q.push_back(res);
        end
        win_old = win_new;
        win_new = '{top: top, mid: mid, bot: pix};
        line_mem[c] = '{upper: mid, middle: pix};
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // transfers in, results out, config writes, all sampled at the rising edge
    always @(posedge aclk) begin : scoreboard
        emboss_res_t got, want;
        if (!aresetn) begin
            foreach (line_mem[i]) line_mem[i] = '0;
            win_old    = '0;
            win_new    = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            s_took     = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                if (embossed_q.size() == 0) begin
                    $display("%0t ns: unexpected result value %0d col %0d row %0d last %0b",
                             $time, got.fval, got.ccol, got.crow, got.flast);
                    errors++;
                end else begin
                    want = embossed_q.pop_front();
                    results_seen++;
                    if (got !== want) begin
                        $display("%0t ns: mismatch expected val %0d col %0d row %0d last %0b pad %h",
                                 $time, want.fval, want.ccol, want.crow, want.flast, want.pad);
                        $display("%0t ns:          actual   val %0d col %0d row %0d last %0b pad %h",
                                 $time, got.fval, got.ccol, got.crow, got.flast, got.pad);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_emboss(s_tdata, s_tuser);
                pixels_sent++;
            end
            if (s_tvalid && !s_tready) stall_cycles++;
            s_took = s_tvalid && s_tready;
            if (cfg_we) begin
                if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
        end
    end

    always @(negedge aclk) begin : pixel_driver
        pixel_item_t nxt;
        logic        offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            offer = 1'b1;
        end else if (pixel_q.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
            nxt = pixel_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= nxt.pix;
            s_tuser  <= nxt.fs;
            offer = 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
        quiet = !offer && pixel_q.size() == 0 && embossed_q.size() == 0;
    end

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (long_hold_go && !hold_used) begin
            // long hold-off so the pipeline fills and stalls the input
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    task automatic wait_quiet();
        int guard;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (!quiet && guard < QUIET_GUARD);
        if (!quiet) begin
            $display("%0t ns: %0d results never arrived, %0d pixels not taken",
                     $time, embossed_q.size(), pixel_q.size());
            errors++;
            embossed_q.delete();
            pixel_q.delete();
        end
        // a pixel with no result may still be in flight
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              output bit grew);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(negedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        grew  = used_dim(w, MAX_WIDTH) > cur_w;
        cur_w = used_dim(w, MAX_WIDTH);
        cur_h = used_dim(h, MAX_HEIGHT);
        n_configs++;
    endtask

    task automatic push_px(input pix_t pix, input logic fs);
        pixel_item_t it;
        it.pix = pix;
        it.fs  = fs;
        pixel_q.push_back(it);
    endtask

    // mostly whole frames with random content, some stray frame starts
    task automatic queue_frames(input int n, input bit restart, input int noise_pct);
        int          pos, area;
        pixel_item_t it;
        area = cur_w * cur_h;
        pos  = 0;
        for (int i = 0; i < n; i++) begin
            it.pix = pick_pixel();
            if (i == 0 && restart) it.fs = 1'b1;
            else if (pos == 0) it.fs = ($urandom_range(99) < 85);
            else it.fs = ($urandom_range(99) < noise_pct);
            if (it.fs) pos = 0;
            pos = (pos + 1) % area;
            pixel_q.push_back(it);
        end
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int sp, input int mp, input int n, input int noise,
                             input bit restart);
        bit grew;
        write_dims(w, h, grew);
        s_idle_pct  = sp;
        m_stall_pct = mp;
        // a wider row than before would read line buffer cells never written
        queue_frames(n, restart || grew, noise);
        wait_quiet();
    endtask

    initial begin : stimulus
        bit grew;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 4x3 frames, negative clamp, positive clamp with frame end,
        // stray pixels, then a restart with an all-white frame
        write_dims(4, 3, grew);
        push_px(8'hFF, 1'b1);
        repeat (10) push_px(8'h00, 1'b0);
        push_px(8'hFF, 1'b0);
        push_px(8'h5A, 1'b0);
        push_px(8'hA5, 1'b0);
        push_px(8'hFF, 1'b1);
        repeat (11) push_px(8'hFF, 1'b0);
        wait_quiet();

        run_phase(3, 5, 79, 0, 40, 3, 1'b0);
        run_phase(7, 4, 0, 79, 40, 3, 1'b0);
        run_phase(0, 2, 25, 25, 30, 3, 1'b0);
        long_hold_go = 1'b1;
        run_phase(5, 9, 0, 0, 60, 3, 1'b0);
        // same setting again after the sender paused for all results
        run_phase(5, 9, 0, 0, 30, 3, 1'b0);
        run_phase(12, 3, 79, 0, 40, 3, 1'b0);
        run_phase(1025, 3, 0, 0, 30, 0, 1'b1);
        run_phase(3, 2047, 25, 25, 30, 0, 1'b1);
        run_phase(6, 6, 0, 79, 40, 3, 1'b0);
        // height shrinks mid frame, counters wrap at the new bound
        run_phase(6, 3, 25, 25, 30, 3, 1'b0);
        run_phase(2047, 2047, 79, 79, 30, 3, 1'b0);

        $display("run covered %0d pixel transfers and %0d filtered results over %0d settings",
                 pixels_sent, results_seen, n_configs);
        $display("input held off for %0d cycles, %0d errors", stall_cycles, errors);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ conv3x3_emboss_clamp.f @@
hw/rtl/c3e_pkg.sv
hw/rtl/c3e_cell.sv
hw/rtl/c3e_line_buf.sv
hw/rtl/conv3x3_emboss_clamp.sv
verif/tb_top.sv
